// File: rtl/core/mpgby_pkg.sv
`timescale 1ns / 1ps

package mpgby_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STILL_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STILL_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STILL_SQ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_TIME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DT          = 3'd4;

    localparam logic signed [DATA_W-1:0] GYRO_STILL_LOW_RST  = 32'sd0;
    localparam logic signed [DATA_W-1:0] GYRO_STILL_HIGH_RST = 32'sd131072;
    localparam logic [DATA_W-1:0]        ACCEL_STILL_SQ_RST  = 32'd429497;
    localparam logic [DATA_W-1:0]        STILL_TIME_RST      = 32'd6554;
    localparam logic [DATA_W-1:0]        MAX_DT_RST          = 32'd65536;

    typedef enum logic [1:0] {
        PAT_STOP      = 2'd0,
        PAT_LINEAR    = 2'd1,
        PAT_ROTATION  = 2'd2,
        PAT_NONLINEAR = 2'd3
    } pattern_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gyro_z;
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic [DATA_W-1:0]        dt;
    } sample_t;

    typedef struct packed {
        logic [1:0]               pattern;
        logic signed [DATA_W-1:0] yaw_delta;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_CLASS,
        ST_DIVSET,
        ST_DIV,
        ST_DIVEND,
        ST_DIFF,
        ST_MUL,
        ST_YAW,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/motion_pattern_gyro_bias_yaw.sv
`timescale 1ns / 1ps

// Motion pattern classifier with gyro bias tracking and yaw integration. One IMU
// sample is taken at a time; the sample port stalls until its result has been
// loaded into the output register. The result is ready after two squares on the
// shared 32x32 multiplier and classification, followed when the gyro is moving by
// one yaw product on the multiplier and a saturation step, when the gyro is
// stopped and the bias mean is refreshed by the 32-step restoring divider for
// sum_reg / count_reg, and when the sample count has saturated by nothing more.
// The finished result waits in its own register, so a stalled result side only
// holds the block when a second result is ready before the first has been taken.
// Configuration writes take effect at once and are meant for idle periods only.
module motion_pattern_gyro_bias_yaw #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpgby_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpgby_pkg::DATA_W-1:0]  cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  mpgby_pkg::sample_t            sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output mpgby_pkg::result_t            result
);

    import mpgby_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration
    logic signed [DATA_W-1:0] gyro_low_reg;
    logic signed [DATA_W-1:0] gyro_high_reg;
    logic [DATA_W-1:0]        accel_sq_reg;
    logic [DATA_W-1:0]        still_time_reg;
    logic [DATA_W-1:0]        max_dt_reg;

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   load_result;

    // held sample
    logic signed [DATA_W-1:0] gyro_reg;
    logic signed [DATA_W-1:0] ax_reg;
    logic signed [DATA_W-1:0] ay_reg;
    logic [DATA_W-1:0]        dt_reg;

    // persistent state
    logic [DATA_W-1:0]        gyro_timer_reg;
    logic [DATA_W-1:0]        accel_timer_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic signed [63:0]       sum_reg;
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [DATA_W-1:0] prev_gyro_reg;

    // working registers
    logic [63:0]              prod_reg;
    logic [63:0]              sq_acc_reg;
    logic [1:0]               pattern_reg;
    logic signed [DATA_W-1:0] yaw_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        dt_eff_reg;
    logic [COUNT_BITS-1:0]    rem_reg;
    logic [DATA_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     gyro_settled_reg;
    result_t                  result_reg;
    logic                     result_valid_reg;

    // shared multiplier
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [63:0]       mul_p;

    // classification
    logic [63:0]       mag_sq;
    logic              gyro_in_band;
    logic              accel_in_band;
    logic [DATA_W:0]   gyro_timer_sum;
    logic [DATA_W:0]   accel_timer_sum;
    logic [DATA_W-1:0] gyro_timer_new;
    logic [DATA_W-1:0] accel_timer_new;
    logic              gyro_settled;
    logic              accel_settled;

    // trapezoid and yaw
    logic signed [DATA_W:0]   gyro_pair;
    logic signed [DATA_W-1:0] avg;
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          diff_abs;
    logic [47:0]              yaw_q;
    logic                     yaw_q_hi_zero;
    logic signed [DATA_W-1:0] yaw_sat;

    // divider
    logic [63:0]           sum_abs;
    logic [COUNT_BITS:0]   div_shift;
    logic [COUNT_BITS:0]   div_sub;
    logic                  div_take;

    function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_low_reg   <= GYRO_STILL_LOW_RST;
            gyro_high_reg  <= GYRO_STILL_HIGH_RST;
            accel_sq_reg   <= ACCEL_STILL_SQ_RST;
            still_time_reg <= STILL_TIME_RST;
            max_dt_reg     <= MAX_DT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GYRO_STILL_LOW:  gyro_low_reg   <= cfg_data;
                CFG_GYRO_STILL_HIGH: gyro_high_reg  <= cfg_data;
                CFG_ACCEL_STILL_SQ:  accel_sq_reg   <= cfg_data;
                CFG_STILL_TIME:      still_time_reg <= cfg_data;
                CFG_MAX_DT:          max_dt_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ---------------- datapath logic ----------------
    always_comb
    begin
        unique case (state_reg)
            ST_SQX:
            begin
                mul_a = abs32(ax_reg);
                mul_b = abs32(ax_reg);
            end
            ST_SQY:
            begin
                mul_a = abs32(ay_reg);
                mul_b = abs32(ay_reg);
            end
            default:
            begin
                mul_a = mag_reg;
                mul_b = dt_eff_reg;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign mag_sq        = sq_acc_reg + prod_reg;
    assign gyro_in_band  = (gyro_reg > gyro_low_reg) && (gyro_reg < gyro_high_reg);
    assign accel_in_band = mag_sq < {32'd0, accel_sq_reg};

    assign gyro_timer_sum  = {1'b0, gyro_timer_reg} + {1'b0, dt_reg};
    assign accel_timer_sum = {1'b0, accel_timer_reg} + {1'b0, dt_reg};

    always_comb
    begin
        if (!gyro_in_band)
            gyro_timer_new = '0;
        else if (gyro_timer_sum[DATA_W])
            gyro_timer_new = '1;
        else
            gyro_timer_new = gyro_timer_sum[DATA_W-1:0];

        if (!accel_in_band)
            accel_timer_new = '0;
        else if (accel_timer_sum[DATA_W])
            accel_timer_new = '1;
        else
            accel_timer_new = accel_timer_sum[DATA_W-1:0];
    end

    assign gyro_settled  = gyro_in_band && (gyro_timer_new > still_time_reg);
    assign accel_settled = accel_in_band && (accel_timer_new > still_time_reg);

    // floor of the pair mean, then distance from the bias
    assign gyro_pair = {gyro_reg[DATA_W-1], gyro_reg} + {prev_gyro_reg[DATA_W-1], prev_gyro_reg};
    assign avg       = gyro_pair[DATA_W:1];
    assign diff      = {avg[DATA_W-1], avg} - {bias_reg[DATA_W-1], bias_reg};
    assign diff_abs  = diff[DATA_W] ? (~diff + 1'b1) : diff;

    assign yaw_q         = prod_reg[63:16];
    assign yaw_q_hi_zero = (yaw_q[47:32] == '0);

    always_comb
    begin
        if (neg_reg)
        begin
            if (yaw_q_hi_zero && (!yaw_q[31] || (yaw_q[30:0] == '0)))
                yaw_sat = ~yaw_q[31:0] + 1'b1;
            else
                yaw_sat = 32'sh8000_0000;
        end
        else
        begin
            if (yaw_q_hi_zero && !yaw_q[31])
                yaw_sat = yaw_q[31:0];
            else
                yaw_sat = 32'sh7fff_ffff;
        end
    end

    // restoring divide step: quotient shifts in as the dividend shifts out
    assign sum_abs   = sum_reg[63] ? (~sum_reg + 1'b1) : sum_reg;
    assign div_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign div_sub   = div_shift - {1'b0, count_reg};
    assign div_take  = !div_sub[COUNT_BITS];

    // ---------------- sequencer ----------------
    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_SQX;
            end
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_CLASS;
            ST_CLASS:
            begin
                if (!gyro_settled)
                    state_next = ST_DIFF;
                else if (count_reg != COUNT_MAX)
                    state_next = ST_DIVSET;
                else
                    state_next = ST_DONE;
            end
            ST_DIVSET: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = ST_DIVEND;
            end
            ST_DIVEND: state_next = ST_DONE;
            ST_DIFF:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_YAW;
            ST_YAW:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sample capture and working registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gyro_reg <= sample.gyro_z;
            ax_reg   <= sample.accel_x;
            ay_reg   <= sample.accel_y;
            dt_reg   <= sample.dt;
        end

        if (state_reg == ST_SQX || state_reg == ST_SQY || state_reg == ST_MUL)
            prod_reg <= mul_p;
        if (state_reg == ST_SQY)
            sq_acc_reg <= prod_reg;

        if (state_reg == ST_CLASS)
        begin
            pattern_reg      <= {!gyro_settled, !accel_settled};
            gyro_settled_reg <= gyro_settled;
        end

        if (state_reg == ST_DIVSET)
        begin
            neg_reg     <= sum_reg[63];
            rem_reg     <= sum_abs[DATA_W +: COUNT_BITS];
            quo_reg     <= sum_abs[DATA_W-1:0];
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg     <= div_take ? div_sub[COUNT_BITS-1:0] : div_shift[COUNT_BITS-1:0];
            quo_reg     <= {quo_reg[DATA_W-2:0], div_take};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end

        if (state_reg == ST_DIFF)
        begin
            neg_reg    <= diff[DATA_W];
            mag_reg    <= diff_abs[DATA_W-1:0];
            dt_eff_reg <= (dt_reg > max_dt_reg) ? '0 : dt_reg;
        end

        if (state_reg == ST_YAW)
            yaw_reg <= yaw_sat;
        else if (state_reg == ST_CLASS)
            yaw_reg <= '0;
    end

    // ---------------- persistent state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_timer_reg  <= '0;
            accel_timer_reg <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            bias_reg        <= '0;
            prev_gyro_reg   <= '0;
        end
        else
        begin
            if (state_reg == ST_CLASS)
            begin
                gyro_timer_reg  <= gyro_timer_new;
                accel_timer_reg <= accel_timer_new;
                if (gyro_settled && count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + 64'(gyro_reg);
                end
            end
            if (state_reg == ST_DIFF)
            begin
                count_reg     <= '0;
                sum_reg       <= '0;
                prev_gyro_reg <= gyro_reg;
            end
            if (state_reg == ST_DIVEND)
                bias_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load_result)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg.pattern   <= pattern_reg;
            result_reg.yaw_delta <= gyro_settled_reg ? '0 : yaw_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
